>>> sv/sfrf_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the shallow-flow Rusanov flux core.
// Used by every module of the block; depends on nothing else.
package sfrf_pkg;

  // Register stages from input capture to the output register.
  localparam int PIPE_DEPTH  = 14;
  // Quotient and square-root bits resolved per iteration stage.
  localparam int ITER_STEPS  = 4;
  localparam int ITER_STAGES = 32 / ITER_STEPS;

  localparam logic [31:0] EPS_RESET = 32'd16777216;
  localparam logic [31:0] COS_RESET = 32'h8000_0000;
  localparam logic [30:0] MIN_RESET = 31'd1;

  localparam logic [31:0] S32_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] S32_MIN = 32'h8000_0000;

  typedef enum logic [1:0] {
    CFG_EPSILON_GAIN = 2'd0,
    CFG_COS_SLOPE    = 2'd1,
    CFG_MIN_DEPTH    = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic signed [31:0] depth_left;
    logic signed [31:0] momentum_left;
    logic signed [31:0] depth_right;
    logic signed [31:0] momentum_right;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] mass_flux;
    logic signed [31:0] momentum_flux;
    logic               saturated;
  } out_item_t;

  // Per-side state carried through the divide and square-root stages.
  typedef struct packed {
    logic [31:0]        div_rem;
    logic [31:0]        div_quo;
    logic [31:0]        div_num;
    logic [30:0]        div_den;
    logic               div_ovf;
    logic [33:0]        sq_rem;
    logic [31:0]        sq_root;
    logic [63:0]        sq_op;
    logic signed [31:0] depth;
    logic signed [31:0] mom;
    logic               neg;
    logic               shallow;
    logic [31:0]        depth_sq;
  } side_t;

  typedef struct packed {
    side_t [1:0] side;
    logic        sat;
  } iter_t;

  typedef struct packed {
    logic [PIPE_DEPTH-1:0] en;
    logic [PIPE_DEPTH-1:0] valid;
  } pipe_ctrl_t;

endpackage

>>> sv/sfrf_pipe_ctrl.sv
`timescale 1ns / 1ps
// Valid tracking and per-stage load enables for the flux pipeline.
// Uses sfrf_pkg; a stage loads when it is empty or its successor loads.
module sfrf_pipe_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 out_stall,
  output sfrf_pkg::pipe_ctrl_t ctl
);

  logic [sfrf_pkg::PIPE_DEPTH-1:0] valid_r;
  logic [sfrf_pkg::PIPE_DEPTH-1:0] valid_nxt;
  logic [sfrf_pkg::PIPE_DEPTH-1:0] en;

  always_comb begin
    en[sfrf_pkg::PIPE_DEPTH-1] = !valid_r[sfrf_pkg::PIPE_DEPTH-1] || !out_stall;
    for (int i = sfrf_pkg::PIPE_DEPTH - 2; i >= 0; i--) begin
      en[i] = !valid_r[i] || en[i+1];
    end
    valid_nxt[0] = en[0] ? in_valid : valid_r[0];
    for (int i = 1; i < sfrf_pkg::PIPE_DEPTH; i++) begin
      valid_nxt[i] = en[i] ? valid_r[i-1] : valid_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign ctl.en    = en;
  assign ctl.valid = valid_r;

endmodule

>>> sv/sfrf_iter_stage.sv
`timescale 1ns / 1ps
// One register stage of the velocity divider and wave-speed square root.
// Uses sfrf_pkg; resolves ITER_STEPS quotient and root bits for both sides.
module sfrf_iter_stage (
  input  logic            clk,
  input  logic            en,
  input  sfrf_pkg::iter_t stage_d,
  output sfrf_pkg::iter_t stage_q
);

  sfrf_pkg::iter_t q_r;
  sfrf_pkg::iter_t q_nxt;

  always_comb begin
    logic [31:0] t;
    logic [35:0] srem;
    logic [35:0] trial;
    q_nxt = stage_d;
    for (int s = 0; s < 2; s++) begin
      for (int k = 0; k < sfrf_pkg::ITER_STEPS; k++) begin
        // Restoring division: the remainder stays below the divisor when it starts below it.
        t = {q_nxt.side[s].div_rem[30:0], q_nxt.side[s].div_num[31]};
        q_nxt.side[s].div_num = {q_nxt.side[s].div_num[30:0], 1'b0};
        if (t >= {1'b0, q_nxt.side[s].div_den}) begin
          q_nxt.side[s].div_rem = t - {1'b0, q_nxt.side[s].div_den};
          q_nxt.side[s].div_quo = {q_nxt.side[s].div_quo[30:0], 1'b1};
        end else begin
          q_nxt.side[s].div_rem = t;
          q_nxt.side[s].div_quo = {q_nxt.side[s].div_quo[30:0], 1'b0};
        end
        // Digit-by-digit square root, two operand bits per root bit.
        srem  = {q_nxt.side[s].sq_rem, q_nxt.side[s].sq_op[63:62]};
        trial = {2'b00, q_nxt.side[s].sq_root, 2'b01};
        q_nxt.side[s].sq_op = {q_nxt.side[s].sq_op[61:0], 2'b00};
        if (srem >= trial) begin
          q_nxt.side[s].sq_rem  = 34'(srem - trial);
          q_nxt.side[s].sq_root = {q_nxt.side[s].sq_root[30:0], 1'b1};
        end else begin
          q_nxt.side[s].sq_rem  = srem[33:0];
          q_nxt.side[s].sq_root = {q_nxt.side[s].sq_root[30:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= q_nxt;
    end
  end

  assign stage_q = q_r;

endmodule

>>> sv/shallow_flow_rusanov_flux_core.sv
`timescale 1ns / 1ps
// Top level of the Rusanov flux core for the 1-D shallow-flow equations.
// Uses sfrf_pkg, sfrf_pipe_ctrl and sfrf_iter_stage.
//
//   channel  direction  handshake             payload
//   in_      input      in_valid / in_stall   sfrf_pkg::in_item_t
//   out_     output     out_valid / out_stall sfrf_pkg::out_item_t
//   cfg_     input      cfg_we                cfg_index, cfg_data
//
// One face enters per cycle, unless in_stall is high, through 14 register stages;
// an accepted request passes the setup, iteration and combine stages to the result register.
// Eight of the stages are divider and root iterations; the rest prepare and combine.
// Reset clears all valid bits and loads the configuration registers with their defaults.
// A stall holds only the stages that are full; empty stages keep filling.
module shallow_flow_rusanov_flux_core #(
  parameter int FRAC_BITS = 20
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  sfrf_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output sfrf_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data
);

  localparam int SHL = (FRAC_BITS >= 24) ? FRAC_BITS - 24 : 0;
  localparam int SHR = (FRAC_BITS < 24) ? 24 - FRAC_BITS : 0;
  localparam int KSH = 56 - FRAC_BITS;
  localparam int NUM_W = 32 + FRAC_BITS;
  localparam logic signed [67:0] LIM_HI = 68'sd2147483647;
  localparam logic signed [67:0] LIM_LO = -68'sd2147483648;

  // Configuration registers and the derived pressure gain.
  logic [31:0] eps_r, cos_r;
  logic [30:0] min_r;
  logic [31:0] k_r;
  logic        k_sat_r;
  logic [63:0] k_prod;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= sfrf_pkg::EPS_RESET;
      cos_r <= sfrf_pkg::COS_RESET;
      min_r <= sfrf_pkg::MIN_RESET;
    end else if (cfg_we) begin
      unique case (sfrf_pkg::cfg_reg_t'(cfg_index))
        sfrf_pkg::CFG_EPSILON_GAIN: eps_r <= cfg_data;
        sfrf_pkg::CFG_COS_SLOPE:    cos_r <= cfg_data;
        sfrf_pkg::CFG_MIN_DEPTH:    min_r <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  assign k_prod = (64'(eps_r) * 64'(cos_r)) >> KSH;

  always_ff @(posedge clk) begin
    k_sat_r <= (k_prod[63:32] != '0);
    k_r     <= (k_prod[63:32] != '0) ? 32'hFFFF_FFFF : k_prod[31:0];
  end

  sfrf_pkg::pipe_ctrl_t ctl;

  sfrf_pipe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .out_stall(out_stall),
    .ctl      (ctl)
  );

  assign in_stall  = !ctl.en[0];
  assign out_valid = ctl.valid[sfrf_pkg::PIPE_DEPTH-1];

  // Stage 1: velocity divide setup and the epsilon*h product.
  logic signed [31:0] s1_depth_r [2];
  logic signed [31:0] s1_mom_r   [2];
  logic               s1_shallow_r [2];
  logic               s1_neg_r   [2];
  logic               s1_ovf_r   [2];
  logic [31:0]        s1_rem_r   [2];
  logic [31:0]        s1_num_r   [2];
  logic [62:0]        s1_p_r     [2];

  always_ff @(posedge clk) begin
    logic signed [31:0] h, hu;
    logic [31:0]        mag;
    logic [NUM_W-1:0]   num;
    logic [31:0]        rem0;
    logic [30:0]        hpos;
    if (ctl.en[0]) begin
      for (int s = 0; s < 2; s++) begin
        h  = (s == 0) ? in_data.depth_left : in_data.depth_right;
        hu = (s == 0) ? in_data.momentum_left : in_data.momentum_right;
        mag  = hu[31] ? 32'(-hu) : 32'(hu);
        num  = {mag, {FRAC_BITS{1'b0}}};
        rem0 = 32'(num >> 32);
        hpos = h[31] ? '0 : h[30:0];
        s1_depth_r[s]   <= h;
        s1_mom_r[s]     <= hu;
        s1_shallow_r[s] <= !(h > $signed({1'b0, min_r}));
        s1_neg_r[s]     <= hu[31];
        s1_ovf_r[s]     <= rem0 >= {1'b0, h[30:0]};
        s1_rem_r[s]     <= rem0;
        s1_num_r[s]     <= num[31:0];
        s1_p_r[s]       <= 63'(eps_r) * 63'(hpos);
      end
    end
  end

  // Stage 2: root operand scaling and the h*h term.
  sfrf_pkg::iter_t s_iter [sfrf_pkg::ITER_STAGES+1];
  sfrf_pkg::iter_t s2_nxt;
  sfrf_pkg::iter_t s2_r;

  always_comb begin
    logic [63:0]        p64;
    logic               povf;
    logic signed [63:0] sqr;
    logic [63:0]        qw;
    s2_nxt = '0;
    for (int s = 0; s < 2; s++) begin
      p64  = {1'b0, s1_p_r[s]};
      povf = (p64 >> (64 - SHL)) != '0;
      sqr  = s1_depth_r[s] * s1_depth_r[s];
      qw   = 64'(sqr) >> FRAC_BITS;
      s2_nxt.side[s].div_rem  = s1_rem_r[s];
      s2_nxt.side[s].div_quo  = '0;
      s2_nxt.side[s].div_num  = s1_num_r[s];
      s2_nxt.side[s].div_den  = s1_depth_r[s][30:0];
      s2_nxt.side[s].div_ovf  = s1_ovf_r[s];
      s2_nxt.side[s].sq_rem   = '0;
      s2_nxt.side[s].sq_root  = '0;
      s2_nxt.side[s].sq_op    = povf ? '1 : ((p64 << SHL) >> SHR);
      s2_nxt.side[s].depth    = s1_depth_r[s];
      s2_nxt.side[s].mom      = s1_mom_r[s];
      s2_nxt.side[s].neg      = s1_neg_r[s];
      s2_nxt.side[s].shallow  = s1_shallow_r[s];
      s2_nxt.side[s].depth_sq = (qw[63:32] != '0) ? 32'hFFFF_FFFF : qw[31:0];
      s2_nxt.sat = s2_nxt.sat | povf | (qw[63:32] != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en[1]) begin
      s2_r <= s2_nxt;
    end
  end

  assign s_iter[0] = s2_r;

  for (genvar g = 0; g < sfrf_pkg::ITER_STAGES; g++) begin : g_iter
    sfrf_iter_stage u_iter (
      .clk    (clk),
      .en     (ctl.en[2+g]),
      .stage_d(s_iter[g]),
      .stage_q(s_iter[g+1])
    );
  end

  // Stage 11: clipped velocity and per-side wave speed.
  logic signed [31:0] s11_u_r     [2];
  logic [32:0]        s11_w_r     [2];
  logic signed [31:0] s11_depth_r [2];
  logic signed [31:0] s11_mom_r   [2];
  logic [31:0]        s11_dsq_r   [2];
  logic               s11_sat_r;

  always_ff @(posedge clk) begin
    sfrf_pkg::side_t sd;
    logic [31:0] u;
    logic [31:0] absu;
    logic        sat;
    if (ctl.en[10]) begin
      sat = s_iter[sfrf_pkg::ITER_STAGES].sat;
      for (int s = 0; s < 2; s++) begin
        sd = s_iter[sfrf_pkg::ITER_STAGES].side[s];
        if (sd.shallow) begin
          u = '0;
        end else if (sd.div_ovf) begin
          u   = sd.neg ? sfrf_pkg::S32_MIN : sfrf_pkg::S32_MAX;
          sat = 1'b1;
        end else if (!sd.neg) begin
          u   = sd.div_quo[31] ? sfrf_pkg::S32_MAX : sd.div_quo;
          sat = sat | sd.div_quo[31];
        end else if (sd.div_quo > sfrf_pkg::S32_MIN) begin
          u   = sfrf_pkg::S32_MIN;
          sat = 1'b1;
        end else begin
          u = -sd.div_quo;
        end
        absu = u[31] ? -u : u;
        s11_u_r[s]     <= $signed(u);
        s11_w_r[s]     <= {1'b0, absu} + {1'b0, sd.sq_root};
        s11_depth_r[s] <= sd.depth;
        s11_mom_r[s]   <= sd.mom;
        s11_dsq_r[s]   <= sd.depth_sq;
      end
      s11_sat_r <= sat;
    end
  end

  // Stage 12: alpha and the physical momentum-flux products.
  logic [30:0]        s12_alpha_r;
  logic signed [63:0] s12_huu_r   [2];
  logic [63:0]        s12_kq_r    [2];
  logic signed [31:0] s12_depth_r [2];
  logic signed [31:0] s12_mom_r   [2];
  logic               s12_sat_r;

  always_ff @(posedge clk) begin
    logic [32:0] aw;
    if (ctl.en[11]) begin
      aw = (s11_w_r[0] > s11_w_r[1]) ? s11_w_r[0] : s11_w_r[1];
      s12_alpha_r <= (aw > 33'(sfrf_pkg::S32_MAX)) ? sfrf_pkg::S32_MAX[30:0] : aw[30:0];
      s12_sat_r   <= s11_sat_r | k_sat_r | (aw > 33'(sfrf_pkg::S32_MAX));
      for (int s = 0; s < 2; s++) begin
        s12_huu_r[s]   <= s11_mom_r[s] * s11_u_r[s];
        s12_kq_r[s]    <= 64'(k_r) * 64'(s11_dsq_r[s]);
        s12_depth_r[s] <= s11_depth_r[s];
        s12_mom_r[s]   <= s11_mom_r[s];
      end
    end
  end

  // Stage 13: physical fluxes and the dissipation terms.
  logic signed [65:0] s13_m_r   [2];
  logic signed [64:0] s13_dh_r;
  logic signed [64:0] s13_dm_r;
  logic signed [31:0] s13_mom_r [2];
  logic               s13_sat_r;

  always_ff @(posedge clk) begin
    logic signed [32:0] diff_h, diff_m;
    logic signed [64:0] ph, pm;
    if (ctl.en[12]) begin
      diff_h = 33'(s12_depth_r[1]) - 33'(s12_depth_r[0]);
      diff_m = 33'(s12_mom_r[1]) - 33'(s12_mom_r[0]);
      ph = $signed({1'b0, s12_alpha_r}) * diff_h;
      pm = $signed({1'b0, s12_alpha_r}) * diff_m;
      s13_dh_r  <= ph >>> FRAC_BITS;
      s13_dm_r  <= pm >>> FRAC_BITS;
      s13_sat_r <= s12_sat_r;
      for (int s = 0; s < 2; s++) begin
        s13_m_r[s]   <= 66'(s12_huu_r[s] >>> FRAC_BITS)
                        + 66'($signed({1'b0, s12_kq_r[s] >> FRAC_BITS}));
        s13_mom_r[s] <= s12_mom_r[s];
      end
    end
  end

  // Stage 14: halve, clip and hold for the consumer.
  sfrf_pkg::out_item_t out_r;

  always_ff @(posedge clk) begin
    logic signed [67:0] fh, fm;
    logic               ch, cm;
    if (ctl.en[13]) begin
      fh = (68'(s13_mom_r[0]) + 68'(s13_mom_r[1]) - 68'(s13_dh_r)) >>> 1;
      fm = (68'(s13_m_r[0]) + 68'(s13_m_r[1]) - 68'(s13_dm_r)) >>> 1;
      ch = (fh > LIM_HI) || (fh < LIM_LO);
      cm = (fm > LIM_HI) || (fm < LIM_LO);
      out_r.mass_flux     <= !ch ? fh[31:0] :
                             (fh > LIM_HI) ? sfrf_pkg::S32_MAX : sfrf_pkg::S32_MIN;
      out_r.momentum_flux <= !cm ? fm[31:0] :
                             (fm > LIM_HI) ? sfrf_pkg::S32_MAX : sfrf_pkg::S32_MIN;
      out_r.saturated     <= s13_sat_r | ch | cm;
    end
  end

  assign out_data = out_r;

`ifndef SYNTH
  // A request is held off only while the result register is full and blocked.
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while the output could drain");

  // An accepted request occupies the first stage on the next cycle.
  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> ctl.valid[0])
    else $error("accepted request lost at stage one");

  // A shallow left state must produce zero velocity.
  a_shallow_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.en[10] && ctl.valid[9] && s_iter[sfrf_pkg::ITER_STAGES].side[0].shallow)
    |=> (s11_u_r[0] == '0))
    else $error("nonzero velocity on a shallow left state");

  // A held output keeps its item.
  a_hold_keeps_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");
`endif

endmodule
